/* src/sha_pkg.sv */
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned LenBits    = 61;
    localparam int unsigned PadStart   = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic t_word initial_h(input logic [2:0] idx);
        t_word h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = '0;
        endcase
        return h;
    endfunction

endpackage

/* src/sha256_stream_hasher.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | i_valid / o_stall   | i_message_byte, i_has_byte, i_end_of_message
// out     | output    | o_valid / i_stall   | o_digest_word, o_word_index, o_last_word,
//         |           |                     | o_length_overflow
// An item that does not fill the block is taken without a stall; a byte that fills
// it stalls the input while the one shared round unit runs 64 rounds and one add.
// End of message pads one byte per cycle up to the block end, then compresses;
// when the 0x80 marker lands at byte 56 or later a second padded block follows.
// The eight digest words then leave one per accepted output item.
// Reset is synchronous, active low, and loads the standard initial hash.
// The input is stalled whenever the sequencer is not in its idle state.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_length_overflow
);
    import sha_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PAD   = 4'b0010,
        S_ROUND = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]         r_fill;      // bytes held in the block buffer
    logic [LenBits-1:0] r_len;       // message bytes so far
    logic               r_ovf;       // sticky length overflow
    logic               r_pad;       // end of message seen, digest not yet sent
    logic               r_first;     // the next padding byte is the 0x80 marker
    logic               r_lenblk;    // the block being padded carries the length
    logic               r_last;      // the running compression is the final one
    logic [63:0]        r_bits;      // bit length, shifted out a byte at a time
    logic [23:0]        r_word;      // first three bytes of the word being built
    logic [3:0]         r_wq;        // buffer word read address during rounds
    logic [2:0]         r_oidx;

    logic       acc, out_acc, wr_byte, start, len_now;
    logic [7:0] byte_d;
    logic       ram_we;
    logic [3:0] ram_wa;
    t_word      ram_wd, ram_rd;
    logic       core_done, core_init;
    t_word      core_word;

    assign acc     = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);

    // Bytes are packed big-endian into words; every fourth byte writes one
    // word of the block buffer.
    assign ram_we = wr_byte && (r_fill[1:0] == 2'b11);
    assign ram_wa = r_fill[5:2];
    assign ram_wd = {r_word, byte_d};

    sha_ram #(.Width(32), .Depth(BlockBytes / 4)) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (r_wq),
        .o_rdata (ram_rd)
    );

    // The padding block holds the length field unless the marker itself
    // falls into the last eight bytes.
    always_comb begin
        wr_byte = 1'b0;
        byte_d  = i_message_byte;
        len_now = r_first ? (r_fill < 6'(PadStart)) : r_lenblk;
        start   = 1'b0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    wr_byte = i_has_byte;
                    if (i_has_byte && r_fill == 6'(BlockBytes - 1)) begin
                        start   = 1'b1;
                        n_state = S_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                wr_byte = 1'b1;
                if (r_first) byte_d = PadByte;
                else if (len_now && r_fill >= 6'(PadStart)) byte_d = r_bits[63:56];
                else byte_d = 8'h00;
                if (r_fill == 6'(BlockBytes - 1)) begin
                    start   = 1'b1;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (core_done) begin
                    if (r_last) n_state = S_OUT;
                    else if (r_pad) n_state = S_PAD;
                    else n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_acc && r_oidx == 3'd7) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The buffer read is registered, so word zero is addressed in the start
    // cycle and word t+1 during round t.
    sha_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_w_word (ram_rd),
        .i_init   (core_init),
        .i_rd_idx (r_oidx),
        .o_done   (core_done),
        .o_rd_word(core_word)
    );

    // The hash returns to its initial value as the last digest word leaves.
    assign core_init = out_acc && (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_pad    <= 1'b0;
            r_first  <= 1'b0;
            r_lenblk <= 1'b0;
            r_last   <= 1'b0;
            r_bits   <= '0;
            r_word   <= '0;
            r_wq     <= '0;
            r_oidx   <= '0;
        end else begin
            r_state <= n_state;
            if (wr_byte) begin
                r_fill <= r_fill + 6'd1;
                r_word <= {r_word[15:0], byte_d};
            end
            if (start) r_wq <= 4'd1;
            else if (r_state == S_ROUND) r_wq <= r_wq + 4'd1;
            else r_wq <= '0;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_has_byte) begin
                            r_len <= r_len + LenBits'(1);
                            if (&r_len) r_ovf <= 1'b1;
                        end
                        if (i_end_of_message) begin
                            r_pad   <= 1'b1;
                            r_first <= 1'b1;
                            r_bits  <= {r_len + LenBits'(i_has_byte), 3'b000};
                        end
                    end
                end
                S_PAD: begin
                    r_first  <= 1'b0;
                    // A block closed without the length is followed by one with it.
                    r_lenblk <= len_now || (r_fill == 6'(BlockBytes - 1));
                    if (!r_first && len_now && r_fill >= 6'(PadStart)) begin
                        r_bits <= {r_bits[55:0], 8'h00};
                    end
                    if (start) r_last <= len_now;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_len  <= '0;
                            r_ovf  <= 1'b0;
                            r_pad  <= 1'b0;
                            r_last <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid           = (r_state == S_OUT);
    assign o_digest_word     = core_word;
    assign o_word_index      = r_oidx;
    assign o_last_word       = (r_oidx == 3'd7);
    assign o_length_overflow = r_ovf;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_word |-> o_word_index == 3'd7) else $error("last mismatch");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("bad state");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word)
        && $stable(o_word_index)) else $error("output changed while stalled");
`endif

endmodule

/* src/sha_core.sv */
module sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sha_pkg::t_word    i_w_word,
    input  logic              i_init,
    input  logic [2:0]        i_rd_idx,
    output logic              o_done,
    output sha_pkg::t_word    o_rd_word
);
    import sha_pkg::*;

    // Rounds run one per cycle; the sixteen-word schedule window slides.
    t_word r_h [8];
    t_word r_v [8];
    t_word r_w [16];
    logic [5:0] r_rnd;
    logic       r_run;
    logic       r_fin;

    t_word wt, s0, s1, wn, t1, t2, ch, mj, sg0, sg1;

    always_comb begin
        s0  = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1  = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
              ^ (r_w[14] >> 10);
        wn  = s1 + r_w[9] + s0 + r_w[0];
        wt  = (r_rnd < 6'd16) ? i_w_word : wn;
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        sg1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
              ^ {r_v[4][24:0], r_v[4][31:25]};
        sg0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
              ^ {r_v[0][21:0], r_v[0][31:22]};
        t1  = r_v[7] + sg1 + ch + round_k(r_rnd) + wt;
        t2  = sg0 + mj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= initial_h(3'(i));
        end else begin
            r_fin <= 1'b0;
            if (i_init) begin
                for (int i = 0; i < 8; i++) r_h[i] <= initial_h(3'(i));
            end else if (i_start) begin
                r_run <= 1'b1;
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end else if (r_run) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wt;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'(Rounds - 1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_done    = r_fin;
    assign o_rd_word = r_h[i_rd_idx];

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run) else $error("start while running");
    a_fin_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> !r_fin) else $error("done held");
    a_fin_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> $past(r_run)) else $error("done without rounds");
`endif

endmodule

/* src/sha_ram.sv */
module sha_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
